// ----- src/assert_macros.svh -----
// Assertion macros shared by the checker files of the pixel scaler.
// Uses clk and rst_n from the scope where a macro is expanded.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication
`define GCPS_ASSERT_NOW(lbl, pre, post, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (pre) |-> (post)) else $error(msg);

// next-cycle implication
`define GCPS_ASSERT_NEXT(lbl, pre, post, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) else $error(msg);

`endif

// ----- src/gcps_pkg.sv -----
// Shared types, constants and elaboration-time curve functions for the scaler.
// No dependencies.
package gcps_pkg;

  localparam int PIX_W      = 8;
  localparam int NUM_CODES  = 2 ** PIX_W;
  localparam int PIX_MAX    = NUM_CODES - 1;
  localparam int GAIN_W     = 11;
  localparam int GAIN_FRAC  = 8;
  localparam int LIN_MAX_W  = 25;   // widest linear value incl. the 1.0 code
  localparam int IDX_MAX_W  = 17;   // widest inverse index incl. the top code
  localparam int BIG_W      = 256;  // exact integer width for curve compares
  localparam int CURVE_NUM  = 11;   // gamma 2.2 = 11/5
  localparam int CURVE_DEN  = 5;

  typedef logic [PIX_W-1:0]  pix_t;
  typedef logic [GAIN_W-1:0] gain_t;
  typedef logic [BIG_W-1:0]  big_t;

  localparam gain_t GAIN_RESET = gain_t'(256);

  function automatic big_t big_pow(big_t base, int e);
    big_t r;
    r = big_t'(1);
    for (int i = 0; i < e; i++) r = r * base;
    return r;
  endfunction

  // v^11 * 2^(5*bits)
  function automatic big_t curve_lhs(int v, int bits);
    return big_pow(big_t'(v), CURVE_NUM) << (CURVE_DEN * bits);
  endfunction

  // lin^5 * 255^11
  function automatic big_t curve_rhs(int lin);
    return big_pow(big_t'(lin), CURVE_DEN) * big_pow(big_t'(PIX_MAX), CURVE_NUM);
  endfunction

  // largest L with L^5 * 255^11 <= c^11 * 2^(5*bits)
  function automatic logic [LIN_MAX_W-1:0] fwd_entry(int c, int bits);
    big_t lhs;
    int   lo;
    int   hi;
    int   mid;
    lhs = curve_lhs(c, bits);
    lo  = 0;
    hi  = 1 << bits;
    while (lo < hi) begin
      mid = lo + ((hi - lo + 1) >> 1);
      if (lhs >= curve_rhs(mid)) lo = mid;
      else hi = mid - 1;
    end
    return LIN_MAX_W'(lo);
  endfunction

  // smallest index i with v^11 * 2^(5*bits) <= i^5 * 255^11
  function automatic logic [IDX_MAX_W-1:0] inv_thr(int v, int bits);
    big_t lhs;
    int   lo;
    int   hi;
    int   mid;
    lhs = curve_lhs(v, bits);
    lo  = 0;
    hi  = 1 << bits;
    while (lo < hi) begin
      mid = lo + ((hi - lo) >> 1);
      if (lhs <= curve_rhs(mid)) hi = mid;
      else lo = mid + 1;
    end
    return IDX_MAX_W'(lo);
  endfunction

endpackage

// ----- src/gcps_front.sv -----
// Front half of one channel: gamma ROM to linear light, gain multiply, clamp;
// plus the direct encoded-value scale. Depends on gcps_pkg.
module gcps_front import gcps_pkg::*; #(
  parameter int LINEAR_BITS = 16
) (
  input  pix_t                 chan,
  input  gain_t                gain,
  output logic [LINEAR_BITS:0] lin_scaled,
  output pix_t                 naive_scaled
);

  localparam int LW   = LINEAR_BITS + 1;
  localparam int SH_W = LW + GAIN_W - GAIN_FRAC;
  localparam logic [SH_W-1:0] ONE_SH = SH_W'(1) << LINEAR_BITS;

  logic [LW-1:0]               fwd_tab [NUM_CODES];
  logic [LW-1:0]               lin_val;
  logic [LW+GAIN_W-1:0]        lin_prod;
  logic [SH_W-1:0]             lin_shift;
  logic [PIX_W+GAIN_W-1:0]     nv_prod;
  logic [GAIN_W-1:0]           nv_shift;

  for (genvar c = 0; c < NUM_CODES; c++) begin : g_fwd
    localparam logic [LIN_MAX_W-1:0] ENTRY = fwd_entry(c, LINEAR_BITS);
    assign fwd_tab[c] = ENTRY[LW-1:0];
  end

  assign lin_val   = fwd_tab[chan];
  assign lin_prod  = {{GAIN_W{1'b0}}, lin_val} * {{LW{1'b0}}, gain};
  assign lin_shift = lin_prod[LW+GAIN_W-1:GAIN_FRAC];
  // saturate at 1.0
  assign lin_scaled = (lin_shift > ONE_SH) ? ONE_SH[LW-1:0] : lin_shift[LW-1:0];

  assign nv_prod  = {{GAIN_W{1'b0}}, chan} * {{PIX_W{1'b0}}, gain};
  assign nv_shift = nv_prod[PIX_W+GAIN_W-1:GAIN_FRAC];
  assign naive_scaled = (nv_shift > GAIN_W'(PIX_MAX)) ? pix_t'(PIX_MAX)
                                                      : nv_shift[PIX_W-1:0];

endmodule

// ----- src/gcps_back.sv -----
// Back half of one channel: index resize, inverse gamma by threshold compare
// and an 8-level select, then mode select. Depends on gcps_pkg.
module gcps_back import gcps_pkg::*; #(
  parameter int LINEAR_BITS        = 16,
  parameter int INVERSE_INDEX_BITS = 12
) (
  input  logic [LINEAR_BITS:0] lin_scaled,
  input  pix_t                 naive_scaled,
  input  logic                 use_linear,
  output pix_t                 result
);

  localparam int KW = INVERSE_INDEX_BITS + 1;

  logic [KW-1:0]        idx;
  logic [NUM_CODES-1:0] above;
  pix_t                 pos;

  if (LINEAR_BITS >= INVERSE_INDEX_BITS) begin : g_idx_down
    assign idx = KW'(lin_scaled >> (LINEAR_BITS - INVERSE_INDEX_BITS));
  end else begin : g_idx_up
    assign idx = {lin_scaled, {(INVERSE_INDEX_BITS - LINEAR_BITS){1'b0}}};
  end

  // thresholds rise with the code, so 'above' is a thermometer
  assign above[0] = 1'b1;
  for (genvar v = 1; v < NUM_CODES; v++) begin : g_thr
    localparam logic [IDX_MAX_W-1:0] THR = inv_thr(v, INVERSE_INDEX_BITS);
    assign above[v] = (idx >= THR[KW-1:0]);
  end

  // highest set position, one bit per level from the MSB
  always_comb begin
    pos = '0;
    for (int b = PIX_W - 1; b >= 0; b--) begin
      if (above[pos | (pix_t'(1) << b)]) pos = pos | (pix_t'(1) << b);
    end
  end

  assign result = use_linear ? pos : naive_scaled;

endmodule

// ----- src/gamma_correct_pixel_scaler.sv -----
// A pixel accepted on in_* passes the input, mid and result registers in order
// before it shows on out_*. Throughput: one pixel per clock unless out_ready
// stalls the output; set by the three-stage valid/ready pipeline. The gain
// multiply and forward gamma ROM sit before the mid register, the
// inverse-gamma compare bank after it. Sync active-low reset empties the
// pipeline and sets gain to 1.0 (256); no clearing pass.
module gamma_correct_pixel_scaler import gcps_pkg::*; #(
  parameter int LINEAR_BITS        = 16,
  parameter int INVERSE_INDEX_BITS = 12
) (
  input  logic  clk,
  input  logic  rst_n,
  input  logic  cfg_valid,
  output logic  cfg_ready,
  input  gain_t cfg_gain,
  input  logic  in_valid,
  output logic  in_ready,
  input  pix_t  in_red_in,
  input  pix_t  in_green_in,
  input  pix_t  in_blue_in,
  input  logic  in_use_linear,
  output logic  out_valid,
  input  logic  out_ready,
  output pix_t  out_red_out,
  output pix_t  out_green_out,
  output pix_t  out_blue_out
);

  localparam int NCH = 3;

  gain_t gain_r;
  logic  s0_valid_r, s0_valid_nxt;
  logic  s1_valid_r, s1_valid_nxt;
  logic  out_valid_r, out_valid_nxt;
  logic  s0_mode_r, s1_mode_r;
  pix_t  s0_chan_r [NCH];
  logic [LINEAR_BITS:0] s1_lin_r [NCH];
  pix_t  s1_naive_r [NCH];
  pix_t  out_chan_r [NCH];
  pix_t  in_chan [NCH];
  logic [LINEAR_BITS:0] lin_scaled [NCH];
  pix_t  naive_scaled [NCH];
  pix_t  result [NCH];
  logic  in_acc, s1_ld, out_ld;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) gain_r <= GAIN_RESET;
    else if (cfg_valid) gain_r <= cfg_gain;
  end

  // per-stage load: a stage fills when empty or when it drains this cycle
  assign out_ld   = s1_valid_r & (~out_valid_r | out_ready);
  assign s1_ld    = s0_valid_r & (~s1_valid_r | out_ld);
  assign in_ready = ~s0_valid_r | s1_ld;
  assign in_acc   = in_valid & in_ready;

  always_comb begin
    s0_valid_nxt = s0_valid_r;
    if (in_acc) s0_valid_nxt = 1'b1;
    else if (s1_ld) s0_valid_nxt = 1'b0;

    s1_valid_nxt = s1_valid_r;
    if (s1_ld) s1_valid_nxt = 1'b1;
    else if (out_ld) s1_valid_nxt = 1'b0;

    out_valid_nxt = out_valid_r;
    if (out_ld) out_valid_nxt = 1'b1;
    else if (out_ready) out_valid_nxt = 1'b0;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s0_valid_r  <= 1'b0;
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      s0_valid_r  <= s0_valid_nxt;
      s1_valid_r  <= s1_valid_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  assign in_chan[0] = in_red_in;
  assign in_chan[1] = in_green_in;
  assign in_chan[2] = in_blue_in;

  always_ff @(posedge clk) begin
    if (in_acc) s0_mode_r <= in_use_linear;
    if (s1_ld) s1_mode_r <= s0_mode_r;
  end

  for (genvar k = 0; k < NCH; k++) begin : g_ch
    gcps_front #(
      .LINEAR_BITS (LINEAR_BITS)
    ) u_front (
      .chan         (s0_chan_r[k]),
      .gain         (gain_r),
      .lin_scaled   (lin_scaled[k]),
      .naive_scaled (naive_scaled[k])
    );

    gcps_back #(
      .LINEAR_BITS        (LINEAR_BITS),
      .INVERSE_INDEX_BITS (INVERSE_INDEX_BITS)
    ) u_back (
      .lin_scaled   (s1_lin_r[k]),
      .naive_scaled (s1_naive_r[k]),
      .use_linear   (s1_mode_r),
      .result       (result[k])
    );

    always_ff @(posedge clk) begin
      if (in_acc) s0_chan_r[k] <= in_chan[k];
      if (s1_ld) begin
        s1_lin_r[k]   <= lin_scaled[k];
        s1_naive_r[k] <= naive_scaled[k];
      end
      if (out_ld) out_chan_r[k] <= result[k];
    end
  end

  assign out_valid     = out_valid_r;
  assign out_red_out   = out_chan_r[0];
  assign out_green_out = out_chan_r[1];
  assign out_blue_out  = out_chan_r[2];

endmodule

// ----- src/gcps_chk.sv -----
// Port-level checker for the pixel scaler, bound to the top level.
// Depends on assert_macros.svh and gcps_pkg.
`include "assert_macros.svh"

module gcps_chk import gcps_pkg::*; (
  input logic clk,
  input logic rst_n,
  input logic in_valid,
  input logic in_ready,
  input logic out_valid,
  input logic out_ready,
  input pix_t out_red_out,
  input pix_t out_green_out,
  input pix_t out_blue_out
);

  // beats accepted but not yet delivered
  logic [2:0] cnt_r, cnt_nxt;

  always_comb begin
    cnt_nxt = cnt_r;
    if ((in_valid && in_ready) && !(out_valid && out_ready)) cnt_nxt = cnt_r + 3'd1;
    else if (!(in_valid && in_ready) && (out_valid && out_ready)) cnt_nxt = cnt_r - 3'd1;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) cnt_r <= '0;
    else cnt_r <= cnt_nxt;
  end

  `GCPS_ASSERT_NEXT(a_out_hold, out_valid && !out_ready, out_valid && $stable(out_red_out) && $stable(out_green_out) && $stable(out_blue_out), "stalled result changed")
  `GCPS_ASSERT_NOW(a_no_invent, out_valid, cnt_r != 3'd0, "result with no pixel in flight")
  `GCPS_ASSERT_NOW(a_depth, 1'b1, cnt_r <= 3'd3, "more beats in flight than stages")
  `GCPS_ASSERT_NOW(a_stall_cause, !in_ready, out_valid && !out_ready, "input stalled without output backpressure")

endmodule

bind gamma_correct_pixel_scaler gcps_chk u_gcps_chk (
  .clk           (clk),
  .rst_n         (rst_n),
  .in_valid      (in_valid),
  .in_ready      (in_ready),
  .out_valid     (out_valid),
  .out_ready     (out_ready),
  .out_red_out   (out_red_out),
  .out_green_out (out_green_out),
  .out_blue_out  (out_blue_out)
);
